>>> sv/dprr_pkg.sv
// ----------------------------------------------------------------------------
// dprr_pkg: shared types and constants for the distance path record/replay
// Command codes, the result item layout and reset values for the other modules.
// ----------------------------------------------------------------------------
package dprr_pkg;

  // Storage depth default (entries of the heading store)
  localparam int unsigned POINT_DEPTH_DEF = 1024;

  // Field widths
  localparam int unsigned DeltaW = 16;
  localparam int unsigned YawW   = 24;
  localparam int unsigned DistW  = 17;
  localparam int unsigned StepW  = 16;
  localparam int unsigned CountW = 10;

  // Distance accumulators saturate at all ones
  localparam logic [DistW-1:0] DIST_MAX   = {DistW{1'b1}};
  localparam logic [StepW-1:0] STEP_RESET = 16'd200;

  // Input command codes
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_REC_START  = 2'd1,
    KIND_REC_STOP   = 2'd2,
    KIND_PLAY_START = 2'd3
  } kind_e;

  // One result item
  typedef struct packed {
    logic               sample_taken;
    logic [CountW-1:0]  point_count;
    logic               replaying;
    logic               recording;
    logic               zero_yaw;
    logic [YawW-1:0]    target_heading;
  } result_t;

endpackage

>>> sv/dprr_ram.sv
// ----------------------------------------------------------------------------
// dprr_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module dprr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/dprr_ctrl.sv
// ----------------------------------------------------------------------------
// dprr_ctrl: record/replay state and heading store
// Applies one command or tick per accepted transaction, updates the mode
// flags, distance accumulators and indexes, and writes/prefetches the store.
// ----------------------------------------------------------------------------
module dprr_ctrl #(
  parameter int unsigned POINT_DEPTH = dprr_pkg::POINT_DEPTH_DEF,
  localparam int unsigned AW = $clog2(POINT_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dprr_pkg::StepW-1:0]     cfg_data_i,
  input  logic                           accept_i,
  input  logic [1:0]                     kind_i,
  input  logic signed [dprr_pkg::DeltaW-1:0] left_delta_i,
  input  logic signed [dprr_pkg::DeltaW-1:0] right_delta_i,
  input  logic [dprr_pkg::YawW-1:0]      yaw_now_i,
  output dprr_pkg::result_t              result_o
);
  import dprr_pkg::*;

  localparam logic [AW-1:0] LastIdx = AW'(POINT_DEPTH - 1);
  localparam logic [AW-1:0] IdxOne  = AW'(1);
  localparam logic [AW-1:0] IdxTwo  = AW'(2);

  // State registers
  logic [StepW-1:0] step_q;
  logic             rec_q, rec_d;
  logic             play_q, play_d;
  logic [DistW-1:0] rdist_q, rdist_d;
  logic [DistW-1:0] pdist_q, pdist_d;
  logic [AW-1:0]    widx_q, widx_d;
  logic [AW-1:0]    ridx_q, ridx_d;
  logic [YawW-1:0]  tgt_q, tgt_d;

  // Next-state values of the step (before the accept gate)
  logic             rec_n, play_n, stop_n, zy_n, sample_n, we_n;
  logic [DistW-1:0] rdist_n, pdist_n;
  logic [AW-1:0]    widx_n, ridx_n;
  logic [YawW-1:0]  tgt_n;

  // Store access
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [YawW-1:0]  ram_rdata;
  logic             fwd_hit_q;
  logic [YawW-1:0]  fwd_data_q;
  logic [YawW-1:0]  next_heading;

  // Tick distance and saturating sums
  logic              tick;
  logic signed [DistW-1:0] sum_s, sum_adj, half_s;
  logic [DistW-1:0]  tick_dist;
  logic [DistW:0]    rsum_w, psum_w;
  logic [DistW-1:0]  rsum, psum;
  logic [AW+CountW-1:0] count_ext;

  // |(l + r) / 2| with truncation toward zero
  always_comb begin
    sum_s     = DistW'(left_delta_i) + DistW'(right_delta_i);
    sum_adj   = sum_s + DistW'(sum_s[DistW-1]);
    half_s    = sum_adj >>> 1;
    tick_dist = half_s[DistW-1] ? DistW'(-half_s) : DistW'(half_s);
    tick      = (kind_e'(kind_i) == KIND_TICK);
  end

  // Entry read_index+1, with the write of the last cycle forwarded
  assign next_heading = fwd_hit_q ? fwd_data_q : ram_rdata;

  // Step logic: command, recording, stop handling, replay advance, end check
  always_comb begin
    rec_n    = rec_q;
    play_n   = play_q;
    stop_n   = 1'b0;
    rdist_n  = rdist_q;
    pdist_n  = pdist_q;
    widx_n   = widx_q;
    ridx_n   = ridx_q;
    tgt_n    = tgt_q;
    zy_n     = 1'b0;
    sample_n = 1'b0;
    we_n     = 1'b0;

    case (kind_e'(kind_i))
      KIND_REC_START: begin
        rec_n   = 1'b1;
        rdist_n = '0;
        widx_n  = '0;
      end
      KIND_REC_STOP: begin
        stop_n = 1'b1;
      end
      KIND_PLAY_START: begin
        play_n  = 1'b1;
        pdist_n = '0;
        ridx_n  = '0;
      end
      default: ;
    endcase

    // Recording accumulator
    rsum_w = {1'b0, rdist_n} + {1'b0, tick_dist};
    rsum   = rsum_w[DistW] ? DIST_MAX : rsum_w[DistW-1:0];
    if (rec_n && tick) begin
      rdist_n = rsum;
      if (rsum >= DistW'(step_q)) begin
        if (widx_n < LastIdx) begin
          widx_n   = widx_n + IdxOne;
          we_n     = 1'b1;
          rdist_n  = '0;
          sample_n = 1'b1;
        end else begin
          stop_n = 1'b1;
        end
      end
    end

    if (stop_n) begin
      rec_n   = 1'b0;
      rdist_n = '0;
      zy_n    = 1'b1;
    end

    // Replay accumulator; ticks never coincide with a replay restart
    psum_w = {1'b0, pdist_n} + {1'b0, tick_dist};
    psum   = psum_w[DistW] ? DIST_MAX : psum_w[DistW-1:0];
    if (play_n && tick) begin
      pdist_n = psum;
      if (psum >= DistW'(step_q)) begin
        pdist_n = '0;
        if (widx_n >= IdxTwo && ridx_n < widx_n - IdxOne) begin
          ridx_n = ridx_n + IdxOne;
          tgt_n  = next_heading;
        end
      end
    end

    // Replay end at the last point or with too few points
    if (play_n && (widx_n < IdxTwo || ridx_n >= widx_n - IdxOne)) begin
      ridx_n = '0;
      play_n = 1'b0;
      tgt_n  = '0;
      zy_n   = 1'b1;
    end
  end

  // Commit only on an accepted transaction
  always_comb begin
    rec_d   = accept_i ? rec_n   : rec_q;
    play_d  = accept_i ? play_n  : play_q;
    rdist_d = accept_i ? rdist_n : rdist_q;
    pdist_d = accept_i ? pdist_n : pdist_q;
    widx_d  = accept_i ? widx_n  : widx_q;
    ridx_d  = accept_i ? ridx_n  : ridx_q;
    tgt_d   = accept_i ? tgt_n   : tgt_q;
    ram_we  = accept_i & we_n;
    ram_raddr = ridx_d + IdxOne;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_RESET;
      rec_q     <= 1'b0;
      play_q    <= 1'b0;
      rdist_q   <= '0;
      pdist_q   <= '0;
      widx_q    <= '0;
      ridx_q    <= '0;
      tgt_q     <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      rec_q     <= rec_d;
      play_q    <= play_d;
      rdist_q   <= rdist_d;
      pdist_q   <= pdist_d;
      widx_q    <= widx_d;
      ridx_q    <= ridx_d;
      tgt_q     <= tgt_d;
      fwd_hit_q <= ram_we && (widx_d == ram_raddr);
    end
  end

  // Forwarded write data
  always_ff @(posedge clk_i) begin
    fwd_data_q <= yaw_now_i;
  end

  dprr_ram #(
    .WIDTH (YawW),
    .DEPTH (POINT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_d),
    .wdata_i (yaw_now_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result of this step
  always_comb begin
    count_ext               = {{CountW{1'b0}}, widx_n};
    result_o.target_heading = tgt_n;
    result_o.zero_yaw       = zy_n;
    result_o.recording      = rec_n;
    result_o.replaying      = play_n;
    result_o.point_count    = count_ext[CountW-1:0];
    result_o.sample_taken   = sample_n;
  end

endmodule

>>> sv/dprr_obuf.sv
// ----------------------------------------------------------------------------
// dprr_obuf: two-entry output buffer
// Output register plus skid register; the upstream ready is a register bit.
// ----------------------------------------------------------------------------
module dprr_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dprr_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dprr_pkg::result_t out_data_o
);
  import dprr_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop, push;

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Buffer update
  always_comb begin
    pop          = out_valid_q & out_ready_i;
    push         = in_valid_i & ~skid_valid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_d       = in_data_i;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = in_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

>>> sv/distance_path_record_replay.sv
// ----------------------------------------------------------------------------
// distance_path_record_replay: heading path recorder and replayer
// Records heading at fixed wheel distance steps and replays it as a target.
//
//   Channel   Direction  Handshake                  Content
//   s_axis    in         s_axis_tvalid/tready       deltas, heading; tuser=kind
//   m_axis    out        m_axis_tvalid/tready       target, flags, point count
//   cfg       in         cfg_valid_i/cfg_ready_o    step distance
//
// One transaction per cycle while s_axis_tready is high; each input transaction
// gives one result. The heading store is read every cycle at read_index+1, so
// the next replay target is always waiting at the RAM output or the forwarding
// register. Reset clears all control state; the store holds no reset value and
// needs no clearing pass. Output stalls are absorbed by a two-entry buffer, so
// input ready drops only once two results wait. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module distance_path_record_replay #(
  parameter int unsigned POINT_DEPTH = dprr_pkg::POINT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,    // step_distance
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // left_delta[15:0], right_delta[31:16], yaw_now[55:32]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // target_heading[23:0], zero_yaw[24], recording[25],
                                     // replaying[26], point_count[36:27],
                                     // sample_taken[37], zero[39:38]
);
  import dprr_pkg::*;

  logic    accept;
  result_t step_res;
  result_t out_res;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid & s_axis_tready;

  dprr_ctrl #(
    .POINT_DEPTH (POINT_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .kind_i        (s_axis_tuser),
    .left_delta_i  (s_axis_tdata[15:0]),
    .right_delta_i (s_axis_tdata[31:16]),
    .yaw_now_i     (s_axis_tdata[55:32]),
    .result_o      (step_res)
  );

  dprr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (step_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // Pack the result, lowest field first
  assign m_axis_tdata = {2'b00, out_res.sample_taken, out_res.point_count,
                         out_res.replaying, out_res.recording, out_res.zero_yaw,
                         out_res.target_heading};

endmodule
